>>> src/psq_pkg.sv
package psq_pkg;

  localparam int QUEUE_DEPTH = 16;

  localparam int NUM_W   = 16;
  localparam int ATIME_W = 20;
  localparam int PRIO_W  = 8;
  localparam int SVC_W   = 16;
  localparam int TIME_W  = 32;

  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [ATIME_W-1:0] atime;
    logic [PRIO_W-1:0]  prio;
    logic [SVC_W-1:0]   svc;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  // higher priority, then earlier arrival, then lower number
  function automatic logic entry_better(input entry_t a, input entry_t b);
    if (a.prio != b.prio) begin
      return a.prio > b.prio;
    end else if (a.atime != b.atime) begin
      return a.atime < b.atime;
    end else begin
      return a.num < b.num;
    end
  endfunction

endpackage

>>> src/psq_cell.sv
module psq_cell
  import psq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  entry_t    left_entry,
  input  logic      left_valid,
  input  logic      left_better,
  input  entry_t    right_entry,
  input  logic      right_valid,
  output entry_t    entry,
  output logic      valid,
  output logic      better
);

  // new item belongs at or before this cell
  assign better = !valid || entry_better(new_entry, entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= right_valid;
    end else if (ctl.ins && better) begin
      valid <= left_better ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      entry <= right_entry;
    end else if (ctl.ins && better) begin
      // shift right behind the insertion point, take the new item at it
      entry <= left_better ? left_entry : new_entry;
    end
  end

endmodule

>>> src/nonpreemptive_priority_scheduler_top.sv
// channel | direction | handshake           | payload
// in      | arrival   | in_valid / in_stall   | arrive_time, prio_level, service_time,
//         |           |                       | final_arrival
// out     | result    | out_valid / out_stall | customer_number, drop_flag, run_end
//
// in_stall is high after an arrival transfer while the sequencer serves jobs due first,
// inserts or drops the arrival, drains on a final one and flushes; then it falls again
// each served job costs one shift of the sorted cell chain, whose head is the best job
// results pass through a one-deep hold stage so run_end is known when they leave
// rst (synchronous) empties the chain, clears the time and restarts numbering at 1
// a stalled output holds back the sequencer only when a further result is ready
module nonpreemptive_priority_scheduler_top
  import psq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ATIME_W-1:0]  arrive_time,
  input  logic [PRIO_W-1:0]   prio_level,
  input  logic [SVC_W-1:0]    service_time,
  input  logic                final_arrival,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [NUM_W-1:0]    customer_number,
  output logic                drop_flag,
  output logic                run_end
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SERVE  = 3'd1;
  localparam logic [2:0] ST_INSERT = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;

  logic [2:0]        state, state_next;
  logic [TIME_W-1:0] cur_time, cur_time_next;
  logic [NUM_W-1:0]  next_number;
  entry_t            arr;
  logic              arr_fin;

  logic              pend_v;
  logic [NUM_W-1:0]  pend_num;
  logic              pend_drop;

  entry_t                 cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_better;
  cell_ctl_t              ctl;

  logic              in_xfer, out_free, gen, gen_drop, load_out, do_load_pend;
  logic [NUM_W-1:0]  gen_num;
  logic              head_v, full, time_early;
  logic [TIME_W:0]   time_sum;
  logic [TIME_W-1:0] time_sat;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign head_v    = cell_valid[0];
  assign full      = cell_valid[QUEUE_DEPTH-1];
  assign time_early = cur_time < {{(TIME_W-ATIME_W){1'b0}}, arr.atime};
  assign time_sum  = {1'b0, cur_time} + {{(TIME_W-SVC_W+1){1'b0}}, cell_entry[0].svc};
  assign time_sat  = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];

  // sequencer
  always_comb begin
    state_next    = state;
    cur_time_next = cur_time;
    ctl           = '0;
    gen           = 1'b0;
    gen_drop      = 1'b0;
    gen_num       = cell_entry[0].num;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_SERVE;
        end
      end
      ST_SERVE: begin
        if (time_early && head_v) begin
          if (!pend_v || out_free) begin
            gen           = 1'b1;
            ctl.pop       = 1'b1;
            cur_time_next = time_sat;
          end
        end else begin
          if (time_early) begin
            cur_time_next = {{(TIME_W-ATIME_W){1'b0}}, arr.atime};
          end
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (full) begin
          if (!pend_v || out_free) begin
            gen        = 1'b1;
            gen_drop   = 1'b1;
            gen_num    = '0;
            state_next = arr_fin ? ST_DRAIN : ST_FLUSH;
          end
        end else begin
          ctl.ins    = 1'b1;
          state_next = arr_fin ? ST_DRAIN : ST_FLUSH;
        end
      end
      ST_DRAIN: begin
        if (head_v) begin
          if (!pend_v || out_free) begin
            gen           = 1'b1;
            ctl.pop       = 1'b1;
            cur_time_next = time_sat;
          end
        end else begin
          cur_time_next = '0;
          state_next    = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign do_load_pend = gen;
  assign load_out = pend_v && out_free && (gen || (state == ST_FLUSH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cur_time    <= '0;
      next_number <= NUM_W'(1);
      pend_v      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      cur_time <= cur_time_next;
      if (in_xfer) begin
        next_number <= (next_number == {NUM_W{1'b1}}) ? NUM_W'(1) : next_number + NUM_W'(1);
      end else if (state == ST_DRAIN && !head_v) begin
        next_number <= NUM_W'(1);
      end
      if (do_load_pend) begin
        pend_v <= 1'b1;
      end else if (load_out) begin
        pend_v <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      arr.num   <= next_number;
      arr.atime <= arrive_time;
      arr.prio  <= prio_level;
      arr.svc   <= service_time;
      arr_fin   <= final_arrival;
    end
    if (do_load_pend) begin
      pend_num  <= gen_num;
      pend_drop <= gen_drop;
    end
    if (load_out) begin
      customer_number <= pend_num;
      drop_flag       <= pend_drop;
      run_end         <= (state == ST_FLUSH);
    end
  end

  // sorted chain, best job at cell 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t le, re;
    logic   lv, lb, rv;
    if (i == 0) begin : g_first
      assign le = '0;
      assign lv = 1'b0;
      assign lb = 1'b0;
    end else begin : g_left
      assign le = cell_entry[i-1];
      assign lv = cell_valid[i-1];
      assign lb = cell_better[i-1];
    end
    if (i == QUEUE_DEPTH-1) begin : g_last
      assign re = '0;
      assign rv = 1'b0;
    end else begin : g_right
      assign re = cell_entry[i+1];
      assign rv = cell_valid[i+1];
    end
    psq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_entry   (arr),
      .left_entry  (le),
      .left_valid  (lv),
      .left_better (lb),
      .right_entry (re),
      .right_valid (rv),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .better      (cell_better[i])
    );
  end

  logic [QUEUE_DEPTH:0] vld_plus;
  assign vld_plus = {1'b0, cell_valid} + (QUEUE_DEPTH+1)'(1);

  // occupied cells form one run from the head
  a_contig: assert property (@(posedge clk) disable iff (rst) $onehot(vld_plus))
    else $error("gap in occupied cells");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    cell_valid[1] |-> !entry_better(cell_entry[1], cell_entry[0]))
    else $error("head is not the best job");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_v)
    else $error("result left in hold stage while idle");

  a_drain_reset: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_DRAIN && state == ST_FLUSH) |->
      (cur_time == '0 && next_number == NUM_W'(1)))
    else $error("run state not restarted after drain");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb
  import psq_pkg::*;
();

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [ATIME_W-1:0] arrive_time;
  logic [PRIO_W-1:0]  prio_level;
  logic [SVC_W-1:0]   service_time;
  logic               final_arrival;
  logic               out_valid;
  logic               out_stall;
  logic [NUM_W-1:0]   customer_number;
  logic               drop_flag;
  logic               run_end;

  typedef struct {
    logic [ATIME_W-1:0] at;
    logic [PRIO_W-1:0]  pr;
    logic [SVC_W-1:0]   sv;
    logic               fin;
    int                 gap;
  } arrival_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic             drop;
    logic             last;
  } outcome_t;

  // scheduler shadow state
  entry_t            sched_slot[QUEUE_DEPTH];
  logic              slot_live[QUEUE_DEPTH];
  logic [TIME_W-1:0] sched_time;
  logic [NUM_W-1:0]  seq_next;
  outcome_t          batch[$];
  outcome_t          service_order[$];

  arrival_t arrival_backlog[$];
  arrival_t cur;
  bit       in_busy = 1'b0;
  bit       took = 1'b0;
  int       stall_left = 0;
  bit       out_calm = 1'b0;
  bit       gen_idle = 1'b1;

  int faults = 0;
  int n_arrivals = 0;
  int n_served = 0;
  int n_drops = 0;
  int n_wraps = 0;

  nonpreemptive_priority_scheduler_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .arrive_time     (arrive_time),
    .prio_level      (prio_level),
    .service_time    (service_time),
    .final_arrival   (final_arrival),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .customer_number (customer_number),
    .drop_flag       (drop_flag),
    .run_end         (run_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic outranks(input entry_t a, input entry_t b);
    if (a.prio != b.prio) begin
      return a.prio > b.prio;
    end
    if (a.atime != b.atime) begin
      return a.atime < b.atime;
    end
    return a.num < b.num;
  endfunction

  function automatic int best_waiting();
    int pick;
    pick = -1;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (slot_live[i] && (pick < 0 || outranks(sched_slot[i], sched_slot[pick]))) begin
        pick = i;
      end
    end
    return pick;
  endfunction

  function automatic void serve_slot(input int idx);
    logic [TIME_W:0] sum;
    outcome_t        res;
    res = '{num: sched_slot[idx].num, drop: 1'b0, last: 1'b0};
    batch = {batch, res};
    sum = {1'b0, sched_time} + {{(TIME_W-SVC_W+1){1'b0}}, sched_slot[idx].svc};
    sched_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    slot_live[idx] = 1'b0;
  endfunction

  function automatic void admit_arrival(input logic [ATIME_W-1:0] at,
                                        input logic [PRIO_W-1:0] pr,
                                        input logic [SVC_W-1:0] sv, input logic fin);
    entry_t   job;
    int       pick;
    int       hole;
    outcome_t drop_res;
    job = '{num: seq_next, atime: at, prio: pr, svc: sv};
    if (seq_next == '1) begin
      seq_next = NUM_W'(1);
      n_wraps++;
    end else begin
      seq_next = seq_next + NUM_W'(1);
    end
    batch.delete();
    // serve while the server frees up before this arrival
    pick = best_waiting();
    while (sched_time < TIME_W'(at) && pick >= 0) begin
      serve_slot(pick);
      pick = best_waiting();
    end
    if (sched_time < TIME_W'(at)) sched_time = TIME_W'(at);
    hole = -1;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (!slot_live[i] && hole < 0) hole = i;
    end
    if (hole >= 0) begin
      sched_slot[hole] = job;
      slot_live[hole] = 1'b1;
    end else begin
      drop_res = '{num: '0, drop: 1'b1, last: 1'b0};
      batch = {batch, drop_res};
    end
    if (fin) begin
      pick = best_waiting();
      while (pick >= 0) begin
        serve_slot(pick);
        pick = best_waiting();
      end
      sched_time = '0;
      seq_next = NUM_W'(1);
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    service_order = {service_order, batch};
  endfunction

  function automatic void add_arrival(input int at, input int pr, input int sv,
                                      input logic fin);
    arrival_t a;
    a.at = ATIME_W'(at > 'hFFFFF ? 'hFFFFF : at);
    a.pr = PRIO_W'(pr);
    a.sv = SVC_W'(sv);
    a.fin = fin;
    a.gap = gen_idle ? $urandom_range(0, 17) : 0;
    arrival_backlog = {arrival_backlog, a};
  endfunction

  // arrival driver
  always @(negedge clk) begin
    if (took) begin
      in_busy = 1'b0;
      took = 1'b0;
    end
    if (!in_busy && arrival_backlog.size() > 0) begin
      if (arrival_backlog[0].gap > 0) begin
        arrival_backlog[0].gap = arrival_backlog[0].gap - 1;
      end else begin
        cur = arrival_backlog.pop_front();
        in_busy = 1'b1;
        arrive_time <= cur.at;
        prio_level <= cur.pr;
        service_time <= cur.sv;
        final_arrival <= cur.fin;
      end
    end
    in_valid <= in_busy;
  end

  // arrival transfers feed the shadow scheduler
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      admit_arrival(arrive_time, prio_level, service_time, final_arrival);
      n_arrivals++;
      took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (service_order.size() == 0) begin
        $error("result transfer with nothing due: customer_number %0d drop_flag %0b",
               customer_number, drop_flag);
        faults++;
      end else begin
        want = service_order.pop_front();
        if (customer_number !== want.num) begin
          $error("customer_number: expected %0d, got %0d", want.num, customer_number);
          faults++;
        end
        if (drop_flag !== want.drop) begin
          $error("drop_flag: expected %0b, got %0b", want.drop, drop_flag);
          faults++;
        end
        if (run_end !== want.last) begin
          $error("run_end: expected %0b, got %0b", want.last, run_end);
          faults++;
        end
        if (want.drop) n_drops++;
        else n_served++;
      end
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall_left = out_calm ? 0 : $urandom_range(0, 17);
    end
  end

  initial begin
    int t;
    int sess_len;
    int style;
    int n_rand;
    int pr;
    int sv;
    logic fin;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    arrive_time = '0;
    prio_level = '0;
    service_time = '0;
    final_arrival = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) slot_live[i] = 1'b0;
    sched_time = '0;
    seq_next = NUM_W'(1);
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // equal priorities, earlier arrival before lower number, reversed input times
    add_arrival(0, 0, 0, 1'b0);
    add_arrival('hFFFFF, 255, 'hFFFF, 1'b0);
    add_arrival(5, 255, 1, 1'b0);
    add_arrival(3, 255, 2, 1'b0);
    add_arrival(3, 255, 0, 1'b1);
    // fill the queue, then a drop, then a dropped final that drains everything
    for (int i = 0; i < QUEUE_DEPTH; i++) add_arrival(0, i * 17, 'hA5A5 ^ (i << 3), 1'b0);
    add_arrival(0, 255, 'hFFFF, 1'b0);
    add_arrival(0, 128, 1, 1'b1);

    n_rand = 0;
    while (n_rand < 100) begin
      sess_len = $urandom_range(1, 30);
      style = $urandom_range(0, 4);
      gen_idle = $urandom_range(0, 3) != 0;
      t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 'hFFFFF) : $urandom_range(0, 1000);
      for (int k = 0; k < sess_len; k++) begin
        case (style)
          0: begin
            // dense: many ties, queue tends to fill
            t = t + $urandom_range(0, 3);
            pr = $urandom_range(0, 3);
            sv = $urandom_range(0, 20);
          end
          1, 2: begin
            t = t + $urandom_range(0, 200);
            pr = $urandom_range(0, 255);
            sv = $urandom_range(0, 300);
          end
          3: begin
            t = t + $urandom_range(0, 70000);
            pr = $urandom_range(0, 255);
            sv = $urandom_range(0, 'hFFFF);
          end
          default: begin
            // noise: arrival times out of order
            t = $urandom_range(0, 'hFFFFF);
            pr = $urandom_range(0, 255);
            sv = $urandom_range(0, 'hFFFF);
          end
        endcase
        if (t > 'hFFFFF) t = 'hFFFFF;
        fin = (k == sess_len - 1) && ($urandom_range(0, 7) != 0);
        add_arrival(t, pr, sv, fin);
        n_rand++;
      end
    end
    add_arrival($urandom_range(0, 'hFFFFF), $urandom_range(0, 255),
                $urandom_range(0, 'hFFFF), 1'b1);

    while (arrival_backlog.size() > 0 || in_busy || service_order.size() > 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    $display("run covered %0d arrivals, %0d served jobs and %0d drop reports",
             n_arrivals, n_served, n_drops);
    $display("ties, a full queue and drains were exercised; numbering wrapped %0d time(s)",
             n_wraps);
    if (faults == 0) begin
      $display("nonpreemptive_priority_scheduler_top verification clean");
    end else begin
      $display("nonpreemptive_priority_scheduler_top verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("nonpreemptive_priority_scheduler_top verification failed");
    $finish;
  end

endmodule
